### rtl/mlfq_pkg.sv
`timescale 1ns / 1ps

package mlfq_pkg;

	localparam int DEFAULT_TASK_SLOTS = 64;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;
	localparam int SLOT_W      = 6;
	localparam int ID_W        = 16;
	localparam int PRIO_IN_W   = 4;
	localparam int LEVEL_W     = 2;
	localparam int PRIO_W      = 2;
	localparam int TICKS_W     = 3;
	localparam int QUANT_W     = 3;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [2:0] {
		CMD_ADMIT    = 3'd0,
		CMD_WAKE     = 3'd1,
		CMD_BLOCK    = 3'd2,
		CMD_FREE     = 3'd3,
		CMD_SET_PRIO = 3'd4,
		CMD_TO_MLFQ  = 3'd5,
		CMD_TO_FCFS  = 3'd6,
		CMD_TICK     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_BAD_PRIO  = 3'd2,
		STS_SAME_MODE = 3'd3,
		STS_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TS_FREE  = 2'd0,
		TS_RUN   = 2'd1,
		TS_BLOCK = 2'd2
	} task_state_t;

	localparam logic [CFG_INDEX_W-1:0] CFG_QUANT0 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANT1 = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANT2 = 2'd2;

	localparam logic [QUANT_W-1:0] QUANT0_RESET = 3'd1;
	localparam logic [QUANT_W-1:0] QUANT1_RESET = 3'd3;
	localparam logic [QUANT_W-1:0] QUANT2_RESET = 3'd5;

	localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd3;
	localparam logic [PRIO_W-1:0]  PRIO_MAX   = 2'd3;
	localparam logic [PRIO_IN_W-1:0] PRIO_LIMIT = 4'd3;
	localparam logic [ID_W-1:0]    ID_RESET   = 16'd1;

	typedef struct packed {
		task_state_t         state;
		logic [ID_W-1:0]     id;
		logic [LEVEL_W-1:0]  level;
		logic [PRIO_W-1:0]   prio;
		logic [TICKS_W-1:0]  ticks;
	} slot_word_t;

	typedef struct packed {
		status_t             status;
		logic                picked;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     id;
		logic [LEVEL_W-1:0]  level;
		logic [PRIO_W-1:0]   prio;
	} result_t;

endpackage

### rtl/mlfq_fcfs_task_scheduler.sv
`timescale 1ns / 1ps

// Wake/block/free read only the addressed slot (none if it is out of range); priority
// or mode rejects answer without a scan; admit and set priority scan until a hit or the
// last slot, a mode switch scans every slot, and a schedule tick scans every slot, then
// charges the pick in MLFQ mode. One command at a time; the next beat is taken in the
// cycle after the result is loaded. The table is scanned one read a cycle, on a read port apart from its write port.
// Reset: a clearing pass marks every slot free; no beat is taken until it ends.
module mlfq_fcfs_task_scheduler
	import mlfq_pkg::*;
#(
	parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] command, [8:3] slot, [24:9] task_id, [28:25] priority_value
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [2:0] status, [3] picked, [9:4] chosen_slot, [25:10] chosen_id,
	// [27:26] queue_level, [29:28] task_priority
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [QUANT_W-1:0]     cfg_data
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_CHARGE,
		ST_DONE
	} fsm_t;

	fsm_t                 state_q;
	cmd_t                 cmd_q;
	logic [ID_W-1:0]      tid_q;
	logic [PRIO_W-1:0]    pv_q;
	logic                 mlfq_q;
	logic [ID_W-1:0]      next_id_q;
	logic [QUANT_W-1:0]   quant_q [3];
	logic [IDX_W-1:0]     clr_q;
	logic [IDX_W-1:0]     iss_q;
	logic [IDX_W-1:0]     last_q;
	logic                 iss_active_q;
	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_addr_s1;
	slot_word_t           rd_word_s1;
	logic                 best_found_q;
	logic [IDX_W-1:0]     best_idx_q;
	slot_word_t           best_word_q;
	result_t              res_q;
	logic                 m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	slot_word_t           mem [TASK_SLOTS];

	cmd_t                 in_cmd;
	logic [SLOT_W-1:0]    in_slot;
	logic [ID_W-1:0]      in_tid;
	logic [PRIO_IN_W-1:0] in_pv;
	logic                 in_range;
	logic                 in_mode_mlfq;

	logic                 admit_hit;
	logic                 prio_hit;
	logic                 cand;
	logic                 better;
	logic                 last_hit;
	slot_word_t           new_word;
	slot_word_t           chg_word;
	logic [TICKS_W:0]     used;
	logic [QUANT_W-1:0]   q_sel;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	slot_word_t           mem_wdata;

	assign in_cmd       = cmd_t'(s_tdata[2:0]);
	assign in_slot      = s_tdata[8:3];
	assign in_tid       = s_tdata[24:9];
	assign in_pv        = s_tdata[28:25];
	assign in_range     = int'(in_slot) < TASK_SLOTS;
	assign in_mode_mlfq = (in_cmd == CMD_TO_MLFQ);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// per-slot decisions on the word read in the previous cycle
	always_comb begin
		admit_hit = (rd_word_s1.state == TS_FREE);
		prio_hit  = (rd_word_s1.state != TS_FREE) && (rd_word_s1.id == tid_q);
		last_hit  = (rd_addr_s1 == last_q);
		cand      = (rd_word_s1.state == TS_RUN) &&
			(!mlfq_q || rd_word_s1.level != LEVEL_NONE);
		if (!best_found_q) begin
			better = cand;
		end else if (mlfq_q) begin
			better = cand && ((rd_word_s1.level < best_word_q.level) ||
				(rd_word_s1.level == LEVEL_LOW && best_word_q.level == LEVEL_LOW &&
				rd_word_s1.prio > best_word_q.prio));
		end else begin
			better = cand && (rd_word_s1.id < best_word_q.id);
		end

		new_word.state = TS_RUN;
		new_word.id    = next_id_q;
		new_word.level = mlfq_q ? LEVEL_TOP : LEVEL_NONE;
		new_word.prio  = mlfq_q ? PRIO_MAX : '0;
		new_word.ticks = '0;
	end

	// quantum accounting of the picked task
	always_comb begin
		chg_word = best_word_q;
		used     = {1'b0, best_word_q.ticks} + 4'd1;
		unique case (best_word_q.level)
			2'd0:    q_sel = quant_q[0];
			2'd1:    q_sel = quant_q[1];
			default: q_sel = quant_q[2];
		endcase
		if (used >= {1'b0, q_sel}) begin
			chg_word.ticks = '0;
			if (best_word_q.level < LEVEL_LOW) begin
				chg_word.level = best_word_q.level + 2'd1;
			end else if (best_word_q.prio != '0) begin
				chg_word.prio = best_word_q.prio - 2'd1;
			end
		end else begin
			chg_word.ticks = used[TICKS_W-1:0];
		end
	end

	// table write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = rd_word_s1;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_SCAN: begin
				if (rd_valid_s1) begin
					unique case (cmd_q)
						CMD_ADMIT: begin
							mem_we    = admit_hit;
							mem_wdata = new_word;
						end
						CMD_WAKE: begin
							mem_we          = (rd_word_s1.state == TS_BLOCK);
							mem_wdata.state = TS_RUN;
						end
						CMD_BLOCK: begin
							mem_we          = (rd_word_s1.state == TS_RUN);
							mem_wdata.state = TS_BLOCK;
						end
						CMD_FREE: begin
							mem_we          = 1'b1;
							mem_wdata.state = TS_FREE;
						end
						CMD_SET_PRIO: begin
							mem_we         = prio_hit;
							mem_wdata.prio = pv_q;
						end
						CMD_TO_MLFQ, CMD_TO_FCFS: begin
							mem_we          = (rd_word_s1.state == TS_RUN);
							mem_wdata.level = (cmd_q == CMD_TO_MLFQ) ? LEVEL_TOP : LEVEL_NONE;
							mem_wdata.prio  = (cmd_q == CMD_TO_MLFQ) ? PRIO_MAX : '0;
							mem_wdata.ticks = '0;
						end
						default: ;
					endcase
				end
			end
			ST_CHARGE: begin
				mem_we    = best_found_q && mlfq_q;
				mem_waddr = best_idx_q;
				mem_wdata = chg_word;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_word_s1 <= mem[iss_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cmd_q        <= CMD_ADMIT;
			mlfq_q       <= 1'b0;
			next_id_q    <= ID_RESET;
			quant_q[0]   <= QUANT0_RESET;
			quant_q[1]   <= QUANT1_RESET;
			quant_q[2]   <= QUANT2_RESET;
			clr_q        <= '0;
			iss_q        <= '0;
			last_q       <= '0;
			iss_active_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			rd_addr_s1   <= '0;
			best_found_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QUANT0: quant_q[0] <= cfg_data;
					CFG_QUANT1: quant_q[1] <= cfg_data;
					CFG_QUANT2: quant_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// read issue runs from iss_q up to last_q
			rd_valid_s1 <= iss_active_q;
			rd_addr_s1  <= iss_q;
			if (iss_active_q) begin
				if (iss_q == last_q) begin
					iss_active_q <= 1'b0;
				end else begin
					iss_q <= iss_q + 1'b1;
				end
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end

				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q        <= in_cmd;
						tid_q        <= in_tid;
						pv_q         <= in_pv[PRIO_W-1:0];
						best_found_q <= 1'b0;
						res_q        <= '0;
						iss_q        <= '0;
						last_q       <= LAST_IDX;
						unique case (in_cmd)
							CMD_WAKE, CMD_BLOCK, CMD_FREE: begin
								if (in_range) begin
									iss_q        <= IDX_W'(in_slot);
									last_q       <= IDX_W'(in_slot);
									iss_active_q <= 1'b1;
									state_q      <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_SET_PRIO: begin
								if (in_pv > PRIO_LIMIT) begin
									res_q.status <= STS_BAD_PRIO;
									state_q      <= ST_DONE;
								end else begin
									iss_active_q <= 1'b1;
									state_q      <= ST_SCAN;
								end
							end
							CMD_TO_MLFQ, CMD_TO_FCFS: begin
								if (mlfq_q == in_mode_mlfq) begin
									res_q.status <= STS_SAME_MODE;
									state_q      <= ST_DONE;
								end else begin
									iss_active_q <= 1'b1;
									state_q      <= ST_SCAN;
								end
							end
							default: begin
								iss_active_q <= 1'b1;
								state_q      <= ST_SCAN;
							end
						endcase
					end
				end

				ST_SCAN: begin
					if (rd_valid_s1) begin
						unique case (cmd_q)
							CMD_ADMIT: begin
								if (admit_hit) begin
									res_q.picked <= 1'b1;
									res_q.slot   <= SLOT_W'(rd_addr_s1);
									res_q.id     <= next_id_q;
									res_q.level  <= new_word.level;
									res_q.prio   <= new_word.prio;
									next_id_q    <= next_id_q + 1'b1;
									iss_active_q <= 1'b0;
									state_q      <= ST_DONE;
								end else if (last_hit) begin
									res_q.status <= STS_FULL;
									state_q      <= ST_DONE;
								end
							end
							CMD_SET_PRIO: begin
								if (prio_hit) begin
									iss_active_q <= 1'b0;
									state_q      <= ST_DONE;
								end else if (last_hit) begin
									res_q.status <= STS_NOT_FOUND;
									state_q      <= ST_DONE;
								end
							end
							CMD_TO_MLFQ, CMD_TO_FCFS: begin
								if (last_hit) begin
									mlfq_q  <= (cmd_q == CMD_TO_MLFQ);
									state_q <= ST_DONE;
								end
							end
							CMD_TICK: begin
								if (better) begin
									best_found_q <= 1'b1;
									best_idx_q   <= rd_addr_s1;
									best_word_q  <= rd_word_s1;
								end
								if (last_hit) begin
									state_q <= ST_CHARGE;
								end
							end
							default: begin
								// single-slot wake, block, free
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				ST_CHARGE: begin
					if (best_found_q) begin
						res_q.picked <= 1'b1;
						res_q.slot   <= SLOT_W'(best_idx_q);
						res_q.id     <= best_word_q.id;
						res_q.level  <= mlfq_q ? chg_word.level : LEVEL_NONE;
						res_q.prio   <= mlfq_q ? chg_word.prio : best_word_q.prio;
					end
					state_q <= ST_CHARGE == ST_CHARGE ? ST_DONE : ST_DONE;
				end

				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, res_q.prio, res_q.level, res_q.id, res_q.slot,
							res_q.picked, res_q.status};
						state_q    <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in progress");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && iss_active_q |-> mem_waddr != iss_q)
		else $error("table read and write hit the same slot");

	a_idle_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[29:4] == '0)
		else $error("result without a chosen task carries task fields");

	a_pick_runnable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHARGE && best_found_q |-> best_word_q.state == TS_RUN)
		else $error("tick picked a slot that is not runnable");

endmodule

### sim/sched_result_checker.sv
`timescale 1ns / 1ps

module sched_result_checker
	import mlfq_pkg::*;
#(
	parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// [2:0] command, [8:3] slot, [24:9] task_id, [28:25] priority_value
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [2:0] status, [3] picked, [9:4] chosen_slot, [25:10] chosen_id,
	// [27:26] queue_level, [29:28] task_priority
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [QUANT_W-1:0]     cfg_data,
	output int                     errors,
	output int                     pending,
	output int                     results_checked,
	output int                     mlfq_ticks,
	output int                     full_rejects
);

	task_state_t         tbl_state [TASK_SLOTS];
	logic [ID_W-1:0]     tbl_id    [TASK_SLOTS];
	logic [LEVEL_W-1:0]  tbl_level [TASK_SLOTS];
	logic [PRIO_W-1:0]   tbl_prio  [TASK_SLOTS];
	logic [TICKS_W-1:0]  tbl_ticks [TASK_SLOTS];
	logic                mlfq_mode;
	logic [ID_W-1:0]     id_counter;
	logic [QUANT_W-1:0]  quanta [3];

	result_t pending_results [$];
	result_t got;
	result_t want;

	function automatic result_t make_result(status_t st, int idx);
		result_t r;
		r = '0;
		r.status = st;
		if (idx >= 0) begin
			r.picked = 1'b1;
			r.slot   = idx[SLOT_W-1:0];
			r.id     = tbl_id[idx];
			r.level  = mlfq_mode ? tbl_level[idx] : LEVEL_NONE;
			r.prio   = tbl_prio[idx];
		end
		return r;
	endfunction

	function automatic void reinit_slot(int i, logic to_mlfq);
		tbl_level[i] = to_mlfq ? LEVEL_TOP : LEVEL_NONE;
		tbl_prio[i]  = to_mlfq ? PRIO_MAX : '0;
		tbl_ticks[i] = '0;
	endfunction

	function automatic result_t apply_command(logic [IN_TDATA_W-1:0] beat);
		cmd_t                 c;
		int                   s;
		logic [ID_W-1:0]      tid;
		logic [PRIO_IN_W-1:0] pv;
		int                   pick;
		logic                 to_mlfq;
		int                   used;
		int                   lv;
		c    = cmd_t'(beat[2:0]);
		s    = int'(beat[8:3]);
		tid  = beat[24:9];
		pv   = beat[28:25];
		pick = -1;
		case (c)
			CMD_ADMIT: begin
				for (int i = 0; i < TASK_SLOTS; i++)
					if (pick < 0 && tbl_state[i] == TS_FREE)
						pick = i;
				if (pick < 0) begin
					full_rejects++;
					return make_result(STS_FULL, -1);
				end
				tbl_id[pick]    = id_counter;
				id_counter      = id_counter + 1'b1;
				tbl_state[pick] = TS_RUN;
				reinit_slot(pick, mlfq_mode);
				return make_result(STS_OK, pick);
			end
			CMD_WAKE: begin
				if (s < TASK_SLOTS && tbl_state[s] == TS_BLOCK)
					tbl_state[s] = TS_RUN;
			end
			CMD_BLOCK: begin
				if (s < TASK_SLOTS && tbl_state[s] == TS_RUN)
					tbl_state[s] = TS_BLOCK;
			end
			CMD_FREE: begin
				if (s < TASK_SLOTS)
					tbl_state[s] = TS_FREE;
			end
			CMD_SET_PRIO: begin
				if (pv > PRIO_LIMIT)
					return make_result(STS_BAD_PRIO, -1);
				for (int i = 0; i < TASK_SLOTS; i++)
					if (pick < 0 && tbl_state[i] != TS_FREE && tbl_id[i] == tid)
						pick = i;
				if (pick < 0)
					return make_result(STS_NOT_FOUND, -1);
				tbl_prio[pick] = pv[PRIO_W-1:0];
			end
			CMD_TO_MLFQ, CMD_TO_FCFS: begin
				to_mlfq = (c == CMD_TO_MLFQ);
				if (mlfq_mode == to_mlfq)
					return make_result(STS_SAME_MODE, -1);
				// only runnable tasks get fresh scheduling fields
				for (int i = 0; i < TASK_SLOTS; i++)
					if (tbl_state[i] == TS_RUN)
						reinit_slot(i, to_mlfq);
				mlfq_mode = to_mlfq;
			end
			CMD_TICK: begin
				if (!mlfq_mode) begin
					for (int i = 0; i < TASK_SLOTS; i++)
						if (tbl_state[i] == TS_RUN && (pick < 0 || tbl_id[i] < tbl_id[pick]))
							pick = i;
					return make_result(STS_OK, pick);
				end
				// first runnable at level 0, then level 1, then best priority at level 2
				for (int l = 0; l < 2; l++)
					for (int i = 0; i < TASK_SLOTS; i++)
						if (pick < 0 && tbl_state[i] == TS_RUN && tbl_level[i] == l)
							pick = i;
				if (pick < 0)
					for (int i = 0; i < TASK_SLOTS; i++)
						if (tbl_state[i] == TS_RUN && tbl_level[i] == LEVEL_LOW &&
						    (pick < 0 || tbl_prio[i] > tbl_prio[pick]))
							pick = i;
				if (pick >= 0) begin
					mlfq_ticks++;
					lv   = int'(tbl_level[pick]);
					used = int'(tbl_ticks[pick]) + 1;
					if (used >= int'(quanta[lv])) begin
						tbl_ticks[pick] = '0;
						if (lv < 2)
							tbl_level[pick] = tbl_level[pick] + 1'b1;
						else if (tbl_prio[pick] > 0)
							tbl_prio[pick] = tbl_prio[pick] - 1'b1;
					end else begin
						tbl_ticks[pick] = used[TICKS_W-1:0];
					end
				end
				return make_result(STS_OK, pick);
			end
		endcase
		return make_result(STS_OK, -1);
	endfunction

	task automatic note_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t checker: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				tbl_state[i] = TS_FREE;
				tbl_id[i]    = '0;
				tbl_level[i] = '0;
				tbl_prio[i]  = '0;
				tbl_ticks[i] = '0;
			end
			mlfq_mode       = 1'b0;
			id_counter      = ID_RESET;
			quanta[0]       = QUANT0_RESET;
			quanta[1]       = QUANT1_RESET;
			quanta[2]       = QUANT2_RESET;
			pending_results.delete();
			errors          = 0;
			pending         = 0;
			results_checked = 0;
			mlfq_ticks      = 0;
			full_rejects    = 0;
		end else begin
			if (cfg_we && cfg_index <= CFG_QUANT2)
				quanta[cfg_index] = cfg_data;
			// check the outgoing beat before queuing the new command's result
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[2:0]);
				got.picked = m_tdata[3];
				got.slot   = m_tdata[9:4];
				got.id     = m_tdata[25:10];
				got.level  = m_tdata[27:26];
				got.prio   = m_tdata[29:28];
				results_checked++;
				if (pending_results.size() == 0) begin
					note_failure($sformatf("result beat with none expected: %h", m_tdata));
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.picked !== want.picked ||
					    got.slot !== want.slot || got.id !== want.id ||
					    got.level !== want.level || got.prio !== want.prio)
						note_failure($sformatf({"result %0d mismatch (expected/actual): ",
							"status %0d/%0d picked %0d/%0d slot %0d/%0d id %0d/%0d ",
							"level %0d/%0d prio %0d/%0d"}, results_checked,
							want.status, got.status, want.picked, got.picked,
							want.slot, got.slot, want.id, got.id,
							want.level, got.level, want.prio, got.prio));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_command(s_tdata));
			pending = pending_results.size();
		end
	end

endmodule

### sim/tb_mlfq_fcfs_task_scheduler.sv
`timescale 1ns / 1ps

module tb_mlfq_fcfs_task_scheduler
	import mlfq_pkg::*;
;

	localparam int CLK_PERIOD  = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 86;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// [2:0] command, [8:3] slot, [24:9] task_id, [28:25] priority_value
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// [2:0] status, [3] picked, [9:4] chosen_slot, [25:10] chosen_id,
	// [27:26] queue_level, [29:28] task_priority
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [QUANT_W-1:0]     cfg_data;

	int errors;
	int pending;
	int results_checked;
	int mlfq_ticks;
	int full_rejects;
	int cycle_count = 0;
	int ids_sent    = 0;
	int cmds_sent   = 0;
	bit tx_steady   = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	mlfq_fcfs_task_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	sched_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.pending        (pending),
		.results_checked(results_checked),
		.mlfq_ticks     (mlfq_ticks),
		.full_rejects   (full_rejects)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending);
			$display("tb_mlfq_fcfs_task_scheduler: FAIL");
			$finish;
		end
	end

	// result side: random stalls, with quiet stretches in between
	initial begin
		int hold;
		int pct;
		int span;
		int r;
		m_tready = 1'b0;
		hold     = 0;
		pct      = 0;
		span     = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span = $urandom_range(100, 400);
				r    = $urandom_range(0, 2);
				pct  = (r == 0) ? 0 : ((r == 1) ? 5 : 25);
			end
			span--;
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else if ($urandom_range(0, 99) < pct) begin
				m_tready = 1'b0;
				r = $urandom_range(0, 99);
				hold = (r < 70) ? $urandom_range(0, 1) :
				       ((r < 95) ? $urandom_range(2, 5) : $urandom_range(20, 60));
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_cmd(cmd_t c, logic [SLOT_W-1:0] sl, logic [ID_W-1:0] id,
	                        logic [PRIO_IN_W-1:0] pv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = '0;
		s_tdata[2:0]   = c;
		s_tdata[8:3]   = sl;
		s_tdata[24:9]  = id;
		s_tdata[28:25] = pv;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		cmds_sent++;
		if (c == CMD_ADMIT)
			ids_sent++;
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_quanta(logic [QUANT_W-1:0] q0, logic [QUANT_W-1:0] q1,
	                          logic [QUANT_W-1:0] q2);
		drain();
		cfg_we    = 1'b1;
		cfg_index = CFG_QUANT0;
		cfg_data  = q0;
		@(negedge clk);
		cfg_index = CFG_QUANT1;
		cfg_data  = q1;
		@(negedge clk);
		cfg_index = CFG_QUANT2;
		cfg_data  = q2;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic send_random(int admit_w);
		int                   r;
		cmd_t                 c;
		logic [SLOT_W-1:0]    sl;
		logic [ID_W-1:0]      id;
		logic [PRIO_IN_W-1:0] pv;
		r = $urandom_range(0, 99);
		if (r < admit_w) begin
			c = CMD_ADMIT;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 12)      c = CMD_WAKE;
			else if (r < 24) c = CMD_BLOCK;
			else if (r < 33) c = CMD_FREE;
			else if (r < 45) c = CMD_SET_PRIO;
			else if (r < 48) c = CMD_TO_MLFQ;
			else if (r < 51) c = CMD_TO_FCFS;
			else             c = CMD_TICK;
		end
		// mostly aim at slots and ids that are likely in use
		sl = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 63)) :
		                                   SLOT_W'($urandom_range(0, 15));
		id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) :
		                                   ID_W'($urandom_range(1, ids_sent + 1));
		pv = ($urandom_range(0, 4) == 0) ? PRIO_IN_W'($urandom_range(4, 15)) :
		                                   PRIO_IN_W'($urandom_range(0, 3));
		send_cmd(c, sl, id, pv);
	endtask

	initial begin
		int admit_w;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the block clears its table before taking the first beat
		while (!s_tready)
			@(negedge clk);

		// directed walk at reset quanta, starting in FCFS mode
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_SET_PRIO, 6'd0,  16'd0,      4'd0);
		send_cmd(CMD_ADMIT,    6'd0,  16'd0,      4'd0);
		send_cmd(CMD_ADMIT,    6'd0,  16'd0,      4'd0);
		send_cmd(CMD_ADMIT,    6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_BLOCK,    6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_WAKE,     6'd63, 16'd0,      4'd0);
		send_cmd(CMD_SET_PRIO, 6'd0,  16'd2,      4'd3);
		send_cmd(CMD_SET_PRIO, 6'd0,  16'hFFFF,   4'd15);
		send_cmd(CMD_SET_PRIO, 6'd0,  16'hFFFF,   4'd0);
		send_cmd(CMD_TO_FCFS,  6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TO_MLFQ,  6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TO_MLFQ,  6'd0,  16'd0,      4'd0);
		// slot 0 wakes with no level assigned and must never be ticked here
		send_cmd(CMD_WAKE,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_ADMIT,    6'd0,  16'd0,      4'd0);
		send_cmd(CMD_FREE,     6'd1,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);
		send_cmd(CMD_SET_PRIO, 6'd0,  16'd3,      4'd0);
		send_cmd(CMD_TO_FCFS,  6'd0,  16'd0,      4'd0);
		send_cmd(CMD_TICK,     6'd0,  16'd0,      4'd0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin set_quanta(3'd7, 3'd7, 3'd7); admit_w = 20; end
				1: begin set_quanta(3'd0, 3'd0, 3'd0); admit_w = 15; end
				2: begin set_quanta(3'd1, 3'd1, 3'd1); admit_w = 60; end
				3: begin
					set_quanta(QUANT_W'($urandom_range(1, 7)), QUANT_W'($urandom_range(1, 7)),
					           QUANT_W'($urandom_range(1, 7)));
					admit_w = 15;
				end
				default: begin set_quanta(3'd1, 3'd3, 3'd5); admit_w = 25; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 30 == 0)
					tx_steady = ($urandom_range(0, 2) == 0);
				if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1)
					drain();
				send_random(admit_w);
			end
		end

		drain();
		repeat (80) @(negedge clk);
		$display("run covered %0d commands and %0d result beats: %0d MLFQ ticks charged,",
			cmds_sent, results_checked, mlfq_ticks);
		$display("%0d admits refused on a full table, six quantum settings", full_rejects);
		if (errors == 0 && pending == 0) begin
			$display("tb_mlfq_fcfs_task_scheduler: PASS");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending);
			$display("tb_mlfq_fcfs_task_scheduler: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/mlfq_pkg.sv
rtl/mlfq_fcfs_task_scheduler.sv
sim/sched_result_checker.sv
sim/tb_mlfq_fcfs_task_scheduler.sv
